/* src/mwm_pkg.sv */
// mwm_pkg: shared types, register codes and the sine table for the mecanum wheel mixer
// no dependencies; used by the stage modules and the top level

package mwm_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_DRIVE_GAIN  = 3'd0,
      CSR_TURN_GAIN   = 3'd1,
      CSR_POWER_LIMIT = 3'd2,
      CSR_DIR_RIGHT   = 3'd3,
      CSR_DIR_FRONT   = 3'd4,
      CSR_DIR_LEFT    = 3'd5,
      CSR_DIR_BACK    = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   // rotation source codes
   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_FRONT = 2'd1,
      MODE_SIDE  = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   // reset values of the configuration registers
   localparam logic [6:0]        DRIVE_GAIN_RST  = 7'd48;
   localparam logic [6:0]        TURN_GAIN_RST   = 7'd25;
   localparam logic [6:0]        POWER_LIMIT_RST = 7'd100;
   localparam logic signed [8:0] DIR_RIGHT_RST   = 9'sd0;
   localparam logic signed [8:0] DIR_FRONT_RST   = 9'sd90;
   localparam logic signed [8:0] DIR_LEFT_RST    = 9'sd180;
   localparam logic signed [8:0] DIR_BACK_RST    = -9'sd90;

   // 1/45 as 23302 / 2^20, exact for quotients that stay below 128
   localparam logic [14:0] RECIP_45   = 15'd23302;
   localparam int          RECIP_SH   = 20;
   localparam logic [12:0] SAT_THRESH = 13'd5760;

   // configuration values handed to the stages
   typedef struct packed {
      logic [6:0]        drive_gain;
      logic [6:0]        turn_gain;
      logic [6:0]        power_limit;
      logic signed [8:0] dir_right;
      logic signed [8:0] dir_front;
      logic signed [8:0] dir_left;
      logic signed [8:0] dir_back;
   } cfg_type;

   // sin(k deg) in Q16, k = 0..90
   function automatic logic [16:0] sin_q16(input logic [6:0] k);
      logic [16:0] v;
      case (k)
         7'd0: v = 17'd0;         7'd1: v = 17'd1144;      7'd2: v = 17'd2287;
         7'd3: v = 17'd3430;      7'd4: v = 17'd4572;      7'd5: v = 17'd5712;
         7'd6: v = 17'd6850;      7'd7: v = 17'd7987;      7'd8: v = 17'd9121;
         7'd9: v = 17'd10252;     7'd10: v = 17'd11380;    7'd11: v = 17'd12505;
         7'd12: v = 17'd13626;    7'd13: v = 17'd14742;    7'd14: v = 17'd15855;
         7'd15: v = 17'd16962;    7'd16: v = 17'd18064;    7'd17: v = 17'd19161;
         7'd18: v = 17'd20252;    7'd19: v = 17'd21336;    7'd20: v = 17'd22415;
         7'd21: v = 17'd23486;    7'd22: v = 17'd24550;    7'd23: v = 17'd25607;
         7'd24: v = 17'd26656;    7'd25: v = 17'd27697;    7'd26: v = 17'd28729;
         7'd27: v = 17'd29753;    7'd28: v = 17'd30767;    7'd29: v = 17'd31772;
         7'd30: v = 17'd32768;    7'd31: v = 17'd33754;    7'd32: v = 17'd34729;
         7'd33: v = 17'd35693;    7'd34: v = 17'd36647;    7'd35: v = 17'd37590;
         7'd36: v = 17'd38521;    7'd37: v = 17'd39441;    7'd38: v = 17'd40348;
         7'd39: v = 17'd41243;    7'd40: v = 17'd42126;    7'd41: v = 17'd42995;
         7'd42: v = 17'd43852;    7'd43: v = 17'd44695;    7'd44: v = 17'd45525;
         7'd45: v = 17'd46341;    7'd46: v = 17'd47143;    7'd47: v = 17'd47930;
         7'd48: v = 17'd48703;    7'd49: v = 17'd49461;    7'd50: v = 17'd50203;
         7'd51: v = 17'd50931;    7'd52: v = 17'd51643;    7'd53: v = 17'd52339;
         7'd54: v = 17'd53020;    7'd55: v = 17'd53684;    7'd56: v = 17'd54332;
         7'd57: v = 17'd54963;    7'd58: v = 17'd55578;    7'd59: v = 17'd56175;
         7'd60: v = 17'd56756;    7'd61: v = 17'd57319;    7'd62: v = 17'd57865;
         7'd63: v = 17'd58393;    7'd64: v = 17'd58903;    7'd65: v = 17'd59396;
         7'd66: v = 17'd59870;    7'd67: v = 17'd60326;    7'd68: v = 17'd60764;
         7'd69: v = 17'd61183;    7'd70: v = 17'd61584;    7'd71: v = 17'd61966;
         7'd72: v = 17'd62328;    7'd73: v = 17'd62672;    7'd74: v = 17'd62997;
         7'd75: v = 17'd63303;    7'd76: v = 17'd63589;    7'd77: v = 17'd63856;
         7'd78: v = 17'd64104;    7'd79: v = 17'd64332;    7'd80: v = 17'd64540;
         7'd81: v = 17'd64729;    7'd82: v = 17'd64898;    7'd83: v = 17'd65048;
         7'd84: v = 17'd65177;    7'd85: v = 17'd65287;    7'd86: v = 17'd65376;
         7'd87: v = 17'd65446;    7'd88: v = 17'd65496;    7'd89: v = 17'd65526;
         7'd90: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

/* src/mwm_req_if.sv */
// mwm_req_if: command channel of the mecanum wheel mixer
// no dependencies

interface mwm_req_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] heading_deg;
   logic [8:0]        magnitude;
   logic [1:0]        mode;
   logic              follow_line;
   logic signed [7:0] line_vert_a;
   logic signed [7:0] line_horiz_a;
   logic signed [7:0] line_vert_b;
   logic signed [7:0] line_horiz_b;
   logic signed [15:0] front_angle;
   logic signed [15:0] side_angle;

   modport source (output valid, heading_deg, magnitude, mode, follow_line, line_vert_a,
                   line_horiz_a, line_vert_b, line_horiz_b, front_angle, side_angle,
                   input ready);
   modport sink (input valid, heading_deg, magnitude, mode, follow_line, line_vert_a,
                 line_horiz_a, line_vert_b, line_horiz_b, front_angle, side_angle,
                 output ready);
endinterface

/* src/mwm_rsp_if.sv */
// mwm_rsp_if: wheel power result channel of the mecanum wheel mixer
// no dependencies

interface mwm_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] wheel_one;
   logic signed [7:0] wheel_two;
   logic signed [7:0] wheel_three;
   logic signed [7:0] wheel_four;
   logic              clamped;

   modport source (output valid, wheel_one, wheel_two, wheel_three, wheel_four, clamped,
                   input ready);
   modport sink (input valid, wheel_one, wheel_two, wheel_three, wheel_four, clamped,
                 output ready);
endinterface

/* src/mwm_csr_if.sv */
// mwm_csr_if: configuration write channel of the mecanum wheel mixer
// no dependencies

interface mwm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [8:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/mwm_steer.sv */
// mwm_steer: first stage, line-sensor heading correction, speed and turn products
// depends on mwm_pkg

module mwm_steer
   import mwm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  cfg_type            cfg,
   input  logic signed [8:0]  heading_deg,
   input  logic [8:0]         magnitude,
   input  logic [1:0]         mode,
   input  logic               follow_line,
   input  logic signed [7:0]  line_vert_a,
   input  logic signed [7:0]  line_horiz_a,
   input  logic signed [7:0]  line_vert_b,
   input  logic signed [7:0]  line_horiz_b,
   input  logic signed [15:0] front_angle,
   input  logic signed [15:0] side_angle,
   output logic               valid_ff,
   output logic signed [10:0] deg_ff,
   output logic [15:0]        md_ff,
   output logic signed [23:0] ta_ff
);

   logic signed [8:0]  hsum, vsum, hq, vq;
   logic signed [10:0] hg, vg, deg_in;
   logic signed [15:0] angle;
   logic signed [23:0] ta_in;
   logic [15:0]        md_in;

   // sensor pair sums, divided by eight toward zero, times five
   always_comb begin
      hsum = 9'(line_horiz_a) + 9'(line_horiz_b);
      vsum = 9'(line_vert_a) + 9'(line_vert_b);
      hq   = (hsum + (hsum[8] ? 9'sd7 : 9'sd0)) >>> 3;
      vq   = (vsum + (vsum[8] ? 9'sd7 : 9'sd0)) >>> 3;
      hg   = (11'(hq) <<< 2) + 11'(hq);
      vg   = (11'(vq) <<< 2) + 11'(vq);
   end

   // heading nudge, first matching direction code wins
   always_comb begin
      deg_in = 11'(heading_deg);
      if (follow_line) begin
         if (heading_deg == cfg.dir_right)      deg_in = 11'(heading_deg) + hg;
         else if (heading_deg == cfg.dir_front) deg_in = 11'(heading_deg) - vg;
         else if (heading_deg == cfg.dir_left)  deg_in = 11'(heading_deg) - hg;
         else if (heading_deg == cfg.dir_back)  deg_in = 11'(heading_deg) + vg;
      end
   end

   // rotation source and products
   always_comb begin
      case (mode_type'(mode))
         MODE_FRONT: angle = front_angle;
         MODE_SIDE:  angle = side_angle;
         default:    angle = 16'sd0;
      endcase
      ta_in = angle * $signed({1'b0, cfg.turn_gain});
      md_in = magnitude * cfg.drive_gain;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff <= deg_in;
         md_ff  <= md_in;
         ta_ff  <= ta_in;
      end
   end

endmodule

/* src/mwm_trig.sv */
// mwm_trig: heading reduction, sine and cosine lookup, then the translation products
// depends on mwm_pkg (sine table)

module mwm_trig
   import mwm_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [10:0]                deg,
   input  logic [15:0]                       md,
   input  logic signed [23:0]                ta,
   output logic                              valid_ff,
   output logic signed [TRIG_FRAC_BITS+18:0] x_ff,
   output logic signed [TRIG_FRAC_BITS+18:0] y_ff,
   output logic signed [23:0]                ta_ff
);

   localparam int          TW   = TRIG_FRAC_BITS + 2;
   localparam int          SH   = 16 - TRIG_FRAC_BITS;
   localparam logic [17:0] HALF = 18'((1 << SH) >> 1);

   logic signed [10:0]  r_wide;
   logic [8:0]          r_sin, r_cos;
   logic [9:0]          r_shift;
   logic signed [TW-1:0] sin_in, cos_in;
   logic                valid2_ff;
   logic signed [TW-1:0] sin_ff, cos_ff;
   logic [15:0]         md2_ff;
   logic signed [23:0]  ta2_ff;

   // sine of r degrees (0..359) at the working fraction width
   function automatic logic signed [TW-1:0] sin_deg(input logic [8:0] r);
      logic [6:0]  k;
      logic        neg;
      logic [17:0] t;
      if (r <= 9'd90) begin
         k = 7'(r); neg = 1'b0;
      end else if (r <= 9'd180) begin
         k = 7'(9'd180 - r); neg = 1'b0;
      end else if (r <= 9'd270) begin
         k = 7'(r - 9'd180); neg = 1'b1;
      end else begin
         k = 7'(9'd360 - r); neg = 1'b1;
      end
      t = (18'(sin_q16(k)) + HALF) >> SH;
      return neg ? -$signed(TW'(t)) : $signed(TW'(t));
   endfunction

   // reduce the heading modulo 360
   always_comb begin
      if (deg < -11'sd360)     r_wide = deg + 11'sd720;
      else if (deg < 11'sd0)   r_wide = deg + 11'sd360;
      else if (deg >= 11'sd360) r_wide = deg - 11'sd360;
      else                     r_wide = deg;
      r_sin   = 9'(r_wide);
      r_shift = 10'(r_sin) + 10'd90;
      r_cos   = (r_shift >= 10'd360) ? 9'(r_shift - 10'd360) : 9'(r_shift);
      sin_in  = sin_deg(r_sin);
      cos_in  = sin_deg(r_cos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else if (en) begin
         valid2_ff <= in_valid;
         valid_ff  <= valid2_ff;
      end
   end

   // trig stage, then product stage
   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
         md2_ff <= md;
         ta2_ff <= ta;
         x_ff   <= cos_ff * $signed({1'b0, md2_ff});
         y_ff   <= sin_ff * $signed({1'b0, md2_ff});
         ta_ff  <= ta2_ff;
      end
   end

endmodule

/* src/mwm_mix.sv */
// mwm_mix: wheel sums over a common denominator, truncation and saturation, output register
// depends on mwm_pkg (reciprocal constants, config struct)

module mwm_mix
   import mwm_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  cfg_type                           cfg,
   input  logic signed [TRIG_FRAC_BITS+18:0] x,
   input  logic signed [TRIG_FRAC_BITS+18:0] y,
   input  logic signed [23:0]                ta,
   output logic                              valid_ff,
   output logic signed [7:0]                 wheel_ff [4],
   output logic                              clamped_ff
);

   localparam int XW = TRIG_FRAC_BITS + 19;
   localparam int PW = TRIG_FRAC_BITS + 27;
   localparam int KS = TRIG_FRAC_BITS + 8;
   localparam int MW = PW - KS;

   logic signed [XW:0]   t_sum [4];
   logic signed [PW-1:0] t45 [4];
   logic signed [PW-1:0] ta_sh;
   logic signed [PW-1:0] p_in [4];
   logic signed [PW-1:0] p_ff [4];
   logic                 valid4_ff;
   logic [PW-1:0]        ap [4];
   logic [MW-1:0]        m [4];
   logic [27:0]          prod [4];
   logic [6:0]           q [4];
   logic                 over [4];
   logic [6:0]           mag_w [4];
   logic signed [7:0]    wheel_in [4];
   logic                 clamped_in;

   // numerator of each wheel: 45 * (+-x + y) +- turn * 2^(F-1)
   always_comb begin
      t_sum[0] = (XW+1)'(x) + (XW+1)'(y);
      t_sum[1] = (XW+1)'(y) - (XW+1)'(x);
      t_sum[2] = (XW+1)'(y) - (XW+1)'(x);
      t_sum[3] = (XW+1)'(x) + (XW+1)'(y);
      ta_sh    = PW'(ta) <<< (TRIG_FRAC_BITS - 1);
      for (int i = 0; i < 4; i++) begin
         t45[i] = (PW'(t_sum[i]) <<< 5) + (PW'(t_sum[i]) <<< 3) + (PW'(t_sum[i]) <<< 2)
                  + PW'(t_sum[i]);
      end
      p_in[0] = t45[0] - ta_sh;
      p_in[1] = t45[1] + ta_sh;
      p_in[2] = t45[2] - ta_sh;
      p_in[3] = t45[3] + ta_sh;
   end

   // truncate toward zero by 45 * 2^(F+8), then saturate to the limit
   always_comb begin
      clamped_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         ap[i]    = p_ff[i][PW-1] ? PW'(-p_ff[i]) : PW'(p_ff[i]);
         m[i]     = MW'(ap[i] >> KS);
         prod[i]  = m[i][12:0] * RECIP_45;
         q[i]     = 7'(prod[i] >> RECIP_SH);
         over[i]  = (m[i] >= MW'(SAT_THRESH)) || (q[i] > cfg.power_limit);
         mag_w[i] = over[i] ? cfg.power_limit : q[i];
         wheel_in[i] = p_ff[i][PW-1] ? -$signed({1'b0, mag_w[i]}) : $signed({1'b0, mag_w[i]});
         clamped_in = clamped_in | over[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else if (en) begin
         valid4_ff <= in_valid;
         valid_ff  <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff       <= p_in;
         wheel_ff   <= wheel_in;
         clamped_ff <= clamped_in;
      end
   end

endmodule

/* src/mecanum_wheel_mixer.sv */
// mecanum_wheel_mixer: inverse kinematics for a four-wheel mecanum base
// pipeline stages, in order from command transfer to result valid: steer, trig, product, sum, saturate
// throughput: one command per cycle; the whole pipeline holds while a result waits unaccepted
// reset: synchronous, clears all stage valid bits and loads the register reset values
// depends on mwm_pkg, mwm_req_if, mwm_rsp_if, mwm_csr_if, mwm_steer, mwm_trig, mwm_mix

module mecanum_wheel_mixer
   import mwm_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 14
) (
   input logic       clock,
   input logic       reset,
   mwm_req_if.sink   req_ch,
   mwm_rsp_if.source rsp_ch,
   mwm_csr_if.sink   csr_ch
);

   cfg_type cfg_ff;
   logic    en;
   logic    s1_valid, s3_valid, out_valid;
   logic signed [10:0] s1_deg;
   logic [15:0]        s1_md;
   logic signed [23:0] s1_ta, s3_ta;
   logic signed [TRIG_FRAC_BITS+18:0] s3_x, s3_y;
   logic signed [7:0]  wheel [4];
   logic               clamped;

   // configuration writes, always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_gain  <= DRIVE_GAIN_RST;
         cfg_ff.turn_gain   <= TURN_GAIN_RST;
         cfg_ff.power_limit <= POWER_LIMIT_RST;
         cfg_ff.dir_right   <= DIR_RIGHT_RST;
         cfg_ff.dir_front   <= DIR_FRONT_RST;
         cfg_ff.dir_left    <= DIR_LEFT_RST;
         cfg_ff.dir_back    <= DIR_BACK_RST;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_DRIVE_GAIN:  cfg_ff.drive_gain  <= csr_ch.data[6:0];
            CSR_TURN_GAIN:   cfg_ff.turn_gain   <= csr_ch.data[6:0];
            CSR_POWER_LIMIT: cfg_ff.power_limit <= csr_ch.data[6:0];
            CSR_DIR_RIGHT:   cfg_ff.dir_right   <= $signed(csr_ch.data);
            CSR_DIR_FRONT:   cfg_ff.dir_front   <= $signed(csr_ch.data);
            CSR_DIR_LEFT:    cfg_ff.dir_left    <= $signed(csr_ch.data);
            CSR_DIR_BACK:    cfg_ff.dir_back    <= $signed(csr_ch.data);
            default: ;
         endcase
      end
   end

   // pipeline advances unless a result is held at the output
   assign en           = !out_valid || rsp_ch.ready;
   assign req_ch.ready = en;

   mwm_steer u_steer (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_ch.valid),
      .cfg          (cfg_ff),
      .heading_deg  (req_ch.heading_deg),
      .magnitude    (req_ch.magnitude),
      .mode         (req_ch.mode),
      .follow_line  (req_ch.follow_line),
      .line_vert_a  (req_ch.line_vert_a),
      .line_horiz_a (req_ch.line_horiz_a),
      .line_vert_b  (req_ch.line_vert_b),
      .line_horiz_b (req_ch.line_horiz_b),
      .front_angle  (req_ch.front_angle),
      .side_angle   (req_ch.side_angle),
      .valid_ff     (s1_valid),
      .deg_ff       (s1_deg),
      .md_ff        (s1_md),
      .ta_ff        (s1_ta)
   );

   mwm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s1_valid),
      .deg      (s1_deg),
      .md       (s1_md),
      .ta       (s1_ta),
      .valid_ff (s3_valid),
      .x_ff     (s3_x),
      .y_ff     (s3_y),
      .ta_ff    (s3_ta)
   );

   mwm_mix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_mix (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s3_valid),
      .cfg        (cfg_ff),
      .x          (s3_x),
      .y          (s3_y),
      .ta         (s3_ta),
      .valid_ff   (out_valid),
      .wheel_ff   (wheel),
      .clamped_ff (clamped)
   );

   // result transfer
   assign rsp_ch.valid       = out_valid;
   assign rsp_ch.wheel_one   = wheel[0];
   assign rsp_ch.wheel_two   = wheel[1];
   assign rsp_ch.wheel_three = wheel[2];
   assign rsp_ch.wheel_four  = wheel[3];
   assign rsp_ch.clamped     = clamped;

endmodule

/* src/mwm_checker.sv */
// mwm_checker: port-level checks of the mecanum wheel mixer, bound to the top level
// depends only on the top-level port signals

module mwm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] wheel_one,
   input logic signed [7:0] wheel_two,
   input logic signed [7:0] wheel_three,
   input logic signed [7:0] wheel_four,
   input logic              clamped
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input backpressure only while a result is held
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("command stalled without output backpressure");

   // saturation keeps every wheel inside the symmetric range
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (wheel_one != -8'sd128 && wheel_two != -8'sd128 &&
                     wheel_three != -8'sd128 && wheel_four != -8'sd128))
      else $error("wheel power outside symmetric range");

   // held result does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(wheel_one) &&
         $stable(wheel_two) && $stable(wheel_three) && $stable(wheel_four) &&
         $stable(clamped)))
      else $error("stalled result changed");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .wheel_one   (rsp_ch.wheel_one),
   .wheel_two   (rsp_ch.wheel_two),
   .wheel_three (rsp_ch.wheel_three),
   .wheel_four  (rsp_ch.wheel_four),
   .clamped     (rsp_ch.clamped)
);
